### rtl/crp_pkg.sv
`default_nettype none
package crp_pkg;

	localparam int MAX_SIDE_DEF = 256;

	localparam int CFG_W    = 9;
	localparam int CHAR_W   = 8;
	localparam int COORD_W  = 20;
	localparam int FRAC_W   = 8;
	localparam int PIX_W    = 8;
	localparam int MODE_W   = 2;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	// positive radius magnitude and its square
	localparam int R_W      = COORD_W - 1;
	localparam int R2_W     = 2 * R_W;
	// pixel offset from centre: 9-bit column at 8 fraction bits against a 20-bit centre
	localparam int DX_W     = COORD_W + 1;
	localparam int SQ_W     = 2 * (DX_W - 1);
	localparam int D2_W     = SQ_W + 1;

	localparam int ONE_UNIT = 1 << FRAC_W;

	localparam int FIFO_DEPTH = 2;

	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DRAW  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BG     = 2'd2;

	localparam logic [CFG_W-1:0]  WIDTH_RST  = 9'd256;
	localparam logic [CFG_W-1:0]  HEIGHT_RST = 9'd256;
	localparam logic [CHAR_W-1:0] BG_RST     = 8'd32;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLEAR,
		OP_DRAW,
		OP_READ,
		OP_REJECT
	} crp_op_t;

	typedef struct packed {
		crp_op_t                    op;
		logic                       filled;
		logic                       thin;
		logic [CFG_W-1:0]           w;
		logic [CFG_W-1:0]           h;
		logic signed [COORD_W-1:0]  cx;
		logic signed [COORD_W-1:0]  cy;
		logic [R2_W-1:0]            r2;
		logic [R2_W-1:0]            inner2;
		logic [CHAR_W-1:0]          ch;
		logic [PIX_W-1:0]           col;
		logic [PIX_W-1:0]           row;
	} crp_cmd_t;

endpackage
`default_nettype wire

### rtl/crp_ram.sv
`default_nettype none
module crp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/crp_fifo.sv
`default_nettype none
module crp_fifo #(
	parameter type item_t = logic,
	parameter int DEPTH = 2
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_data,
	output logic       full,
	input  wire logic  pop,
	output item_t      pop_data,
	output logic       empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/crp_front.sv
`default_nettype none
module crp_front #(
	parameter int MAX_SIDE = 256
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [crp_pkg::MODE_W-1:0]         mode,
	input  wire logic                               shape,
	input  wire logic signed [crp_pkg::COORD_W-1:0] center_x,
	input  wire logic signed [crp_pkg::COORD_W-1:0] center_y,
	input  wire logic signed [crp_pkg::COORD_W-1:0] radius,
	input  wire logic [crp_pkg::CHAR_W-1:0]         paint_char,
	input  wire logic [crp_pkg::PIX_W-1:0]          pixel_col,
	input  wire logic [crp_pkg::PIX_W-1:0]          pixel_row,
	input  wire logic [crp_pkg::CFG_W-1:0]          cfg_width,
	input  wire logic [crp_pkg::CFG_W-1:0]          cfg_height,
	input  wire logic [crp_pkg::CHAR_W-1:0]         cfg_bg,
	input  wire logic                               q_full,
	output logic                                    q_push,
	output crp_pkg::crp_cmd_t                       q_data
);
	import crp_pkg::*;

	logic                      s1_v;
	logic [MODE_W-1:0]         mode_s1;
	logic                      shape_s1;
	logic signed [COORD_W-1:0] cx_s1;
	logic signed [COORD_W-1:0] cy_s1;
	logic signed [COORD_W-1:0] r_s1;
	logic [CHAR_W-1:0]         ch_s1;
	logic [PIX_W-1:0]          col_s1;
	logic [PIX_W-1:0]          row_s1;

	logic             accept;
	logic [CFG_W-1:0] w_used;
	logic [CFG_W-1:0] h_used;
	logic [R_W-1:0]   r_mag;
	logic [R_W-1:0]   inner;
	logic             thin;
	logic             reject;
	logic             in_area;

	// hold the stage only while the queue is full
	assign busy   = s1_v & q_full;
	assign accept = start & ~busy;
	assign q_push = s1_v & ~q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else begin
			s1_v <= accept | (s1_v & q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= mode;
			shape_s1 <= shape;
			cx_s1    <= center_x;
			cy_s1    <= center_y;
			r_s1     <= radius;
			ch_s1    <= paint_char;
			col_s1   <= pixel_col;
			row_s1   <= pixel_row;
		end
	end

	always_comb begin
		// zero acts as one, oversize as the full side
		if (cfg_width == '0) begin
			w_used = CFG_W'(1);
		end else if (int'(cfg_width) > MAX_SIDE) begin
			w_used = CFG_W'(MAX_SIDE);
		end else begin
			w_used = cfg_width;
		end
		if (cfg_height == '0) begin
			h_used = CFG_W'(1);
		end else if (int'(cfg_height) > MAX_SIDE) begin
			h_used = CFG_W'(MAX_SIDE);
		end else begin
			h_used = cfg_height;
		end
	end

	assign r_mag   = r_s1[R_W-1:0];
	assign reject  = r_s1[COORD_W-1] | (r_s1 == '0);
	assign thin    = (r_mag < R_W'(ONE_UNIT));
	assign inner   = r_mag - R_W'(ONE_UNIT);
	assign in_area = ({1'b0, col_s1} < w_used) && ({1'b0, row_s1} < h_used);

	always_comb begin
		q_data        = '0;
		q_data.w      = w_used;
		q_data.h      = h_used;
		q_data.filled = shape_s1;
		q_data.thin   = thin;
		q_data.cx     = cx_s1;
		q_data.cy     = cy_s1;
		q_data.r2     = r_mag * r_mag;
		q_data.inner2 = thin ? '0 : inner * inner;
		q_data.ch     = ch_s1;
		q_data.col    = col_s1;
		q_data.row    = row_s1;
		case (mode_s1)
			MODE_CLEAR: begin
				q_data.op = OP_CLEAR;
				q_data.ch = cfg_bg;
			end
			MODE_DRAW:  q_data.op = reject ? OP_REJECT : OP_DRAW;
			MODE_READ:  q_data.op = in_area ? OP_READ : OP_NONE;
			default:    q_data.op = OP_NONE;
		endcase
	end

endmodule
`default_nettype wire

### rtl/crp_back.sv
`default_nettype none
module crp_back #(
	parameter int MAX_SIDE = 256,
	localparam int ADDR_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_empty,
	input  wire crp_pkg::crp_cmd_t           q_data,
	output logic                             q_pop,
	output logic                             mem_we,
	output logic [ADDR_W-1:0]                mem_waddr,
	output logic [crp_pkg::CHAR_W-1:0]       mem_wdata,
	output logic [ADDR_W-1:0]                mem_raddr,
	input  wire logic [crp_pkg::CHAR_W-1:0]  mem_rdata,
	output logic                             done,
	output logic [crp_pkg::PIX_W-1:0]        pixel_value,
	output logic                             status
);
	import crp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_DRAW,
		ST_DRAIN,
		ST_READ,
		ST_RDWAIT
	} state_t;

	state_t            st_q;
	crp_cmd_t          cmd_q;
	logic [CFG_W-1:0]  x_q;
	logic [CFG_W-1:0]  y_q;
	logic [ADDR_W-1:0] row_base_q;

	logic              last_pix;
	logic [ADDR_W-1:0] cur_addr;
	logic              pipe_busy;

	logic                     s1_v, s2_v, s3_v;
	logic signed [DX_W-1:0]   dx_s1, dy_s1;
	logic [ADDR_W-1:0]        addr_s1, addr_s2, addr_s3;
	logic [SQ_W-1:0]          dx2_s2, dy2_s2;
	logic [D2_W-1:0]          d2_s3;
	logic signed [2*DX_W-1:0] dx_prod, dy_prod;
	logic                     paint;

	assign last_pix  = (x_q == cmd_q.w - 1'b1) && (y_q == cmd_q.h - 1'b1);
	assign cur_addr  = row_base_q + ADDR_W'(x_q);
	assign pipe_busy = s1_v | s2_v | s3_v;
	assign q_pop     = (st_q == ST_IDLE) & ~q_empty;

	// covered, and for an outline with radius of one unit or more also outside the inner circle
	assign paint = (d2_s3 <= D2_W'(cmd_q.r2)) &&
		(cmd_q.filled || cmd_q.thin || (d2_s3 > D2_W'(cmd_q.inner2)));

	assign mem_we    = (st_q == ST_CLEAR) | (s3_v & paint);
	assign mem_waddr = (st_q == ST_CLEAR) ? cur_addr : addr_s3;
	assign mem_wdata = cmd_q.ch;
	assign mem_raddr = ADDR_W'(cmd_q.row) * ADDR_W'(MAX_SIDE) + ADDR_W'(cmd_q.col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			x_q         <= '0;
			y_q         <= '0;
			row_base_q  <= '0;
			done        <= 1'b0;
			pixel_value <= '0;
			status      <= 1'b0;
		end else begin
			done        <= 1'b0;
			pixel_value <= '0;
			status      <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (!q_empty) begin
						x_q        <= '0;
						y_q        <= '0;
						row_base_q <= '0;
						case (q_data.op)
							OP_CLEAR:  st_q <= ST_CLEAR;
							OP_DRAW:   st_q <= ST_DRAW;
							OP_READ:   st_q <= ST_READ;
							OP_REJECT: begin
								done   <= 1'b1;
								status <= 1'b1;
							end
							default:   done <= 1'b1;
						endcase
					end
				end
				ST_CLEAR, ST_DRAW: begin
					if (x_q == cmd_q.w - 1'b1) begin
						x_q        <= '0;
						y_q        <= y_q + 1'b1;
						row_base_q <= row_base_q + ADDR_W'(MAX_SIDE);
					end else begin
						x_q <= x_q + 1'b1;
					end
					if (last_pix) begin
						if (st_q == ST_CLEAR) begin
							st_q <= ST_IDLE;
							done <= 1'b1;
						end else begin
							st_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						st_q <= ST_IDLE;
						done <= 1'b1;
					end
				end
				ST_READ:   st_q <= ST_RDWAIT;
				ST_RDWAIT: begin
					st_q        <= ST_IDLE;
					done        <= 1'b1;
					pixel_value <= mem_rdata;
				end
				default:   st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_data;
		end
	end

	// distance pipeline: offsets, squares, sum; the compare feeds the write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
			s2_v <= 1'b0;
			s3_v <= 1'b0;
		end else begin
			s1_v <= (st_q == ST_DRAW);
			s2_v <= s1_v;
			s3_v <= s2_v;
		end
	end

	assign dx_prod = dx_s1 * dx_s1;
	assign dy_prod = dy_s1 * dy_s1;

	always_ff @(posedge clk) begin
		dx_s1   <= DX_W'($signed({1'b0, x_q, {FRAC_W{1'b0}}})) - DX_W'(cmd_q.cx);
		dy_s1   <= DX_W'($signed({1'b0, y_q, {FRAC_W{1'b0}}})) - DX_W'(cmd_q.cy);
		addr_s1 <= cur_addr;
		dx2_s2  <= dx_prod[SQ_W-1:0];
		dy2_s2  <= dy_prod[SQ_W-1:0];
		addr_s2 <= addr_s1;
		d2_s3   <= D2_W'(dx2_s2) + D2_W'(dy2_s2);
		addr_s3 <= addr_s2;
	end

endmodule
`default_nettype wire

### rtl/circle_raster_painter_unit.sv
`default_nettype none
// Character canvas with clear, circle draw and pixel read commands.
// Clear and draw take one cycle per pixel of the area in use; a rejected draw,
// an unused mode or a read outside the area finishes without a canvas access.
// The single canvas write port, one pixel a cycle, sets the rate of clear and draw.
// done pulses for one cycle per command; the receiver cannot stall.
// Reset clears control state, loads register defaults; canvas undefined until written.
module circle_raster_painter_unit #(
	parameter int MAX_SIDE = crp_pkg::MAX_SIDE_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [crp_pkg::PADDR_W-1:0]        paddr,
	input  wire logic [crp_pkg::PDATA_W-1:0]        pwdata,
	output logic      [crp_pkg::PDATA_W-1:0]        prdata,
	output logic                                    pready,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [crp_pkg::MODE_W-1:0]         mode,
	input  wire logic                               shape,
	input  wire logic signed [crp_pkg::COORD_W-1:0] center_x,
	input  wire logic signed [crp_pkg::COORD_W-1:0] center_y,
	input  wire logic signed [crp_pkg::COORD_W-1:0] radius,
	input  wire logic [crp_pkg::CHAR_W-1:0]         paint_char,
	input  wire logic [crp_pkg::PIX_W-1:0]          pixel_col,
	input  wire logic [crp_pkg::PIX_W-1:0]          pixel_row,
	output logic                                    done,
	output logic [crp_pkg::PIX_W-1:0]               pixel_value,
	output logic                                    status
);
	import crp_pkg::*;

	localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W = (MAX_SIDE > 1) ? $clog2(DEPTH) : 1;

	// register file
	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic [CHAR_W-1:0] bg_q;
	logic              cfg_wr;

	// front to back queue
	crp_cmd_t q_push_data;
	crp_cmd_t q_pop_data;
	logic     q_push;
	logic     q_pop;
	logic     q_full;
	logic     q_empty;

	// canvas port
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CHAR_W-1:0] mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic [CHAR_W-1:0] mem_rdata;

	// APB: zero wait states; a write takes effect on the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			bg_q     <= BG_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
				REG_BG:     bg_q     <= pwdata[CHAR_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WIDTH:  prdata = PDATA_W'(width_q);
			REG_HEIGHT: prdata = PDATA_W'(height_q);
			REG_BG:     prdata = PDATA_W'(bg_q);
			default:    prdata = '0;
		endcase
	end

	// front: takes the command transaction, clamps the area, squares the radius
	crp_front #(
		.MAX_SIDE (MAX_SIDE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.shape      (shape),
		.center_x   (center_x),
		.center_y   (center_y),
		.radius     (radius),
		.paint_char (paint_char),
		.pixel_col  (pixel_col),
		.pixel_row  (pixel_row),
		.cfg_width  (width_q),
		.cfg_height (height_q),
		.cfg_bg     (bg_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_push_data)
	);

	// short queue so the front keeps taking commands while a sweep runs
	crp_fifo #(
		.item_t (crp_cmd_t),
		.DEPTH  (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.empty     (q_empty)
	);

	// back: pixel sweeps for clear and draw, single reads, result strobe
	crp_back #(
		.MAX_SIDE (MAX_SIDE)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (q_pop_data),
		.q_pop       (q_pop),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata),
		.done        (done),
		.pixel_value (pixel_value),
		.status      (status)
	);

	// canvas, row stride MAX_SIDE
	crp_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (DEPTH)
	) u_canvas (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

`ifndef SYNTH
	// a command finishes only once its last canvas write has gone
	a_no_write_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !mem_we)
		else $error("canvas write while result is presented");

	// result ports are quiet between strobes
	a_quiet_outputs: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> (pixel_value == '0 && !status))
		else $error("result ports active without done");

	// a rejected draw never carries pixel data
	a_reject_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		status |-> (pixel_value == '0))
		else $error("pixel value on rejected draw");

	// the queue only pops when it holds a command
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue popped while empty");
`endif

endmodule
`default_nettype wire
